### design/lca_pkg.sv
// shared types, codes and widths for the lowest common ancestor counter
package lca_pkg;

    localparam int NODE_W   = 10;
    localparam int COUNT_W  = 16;
    localparam int TAG_W    = 8;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_ANC = 2'd2;

    // mark tags: zero is never a live query epoch
    localparam logic [TAG_W-1:0] TAG_NONE  = {TAG_W{1'b0}};
    localparam logic [TAG_W-1:0] TAG_FIRST = {{(TAG_W-1){1'b0}}, 1'b1};
    localparam logic [TAG_W-1:0] TAG_MAX   = {TAG_W{1'b1}};

    localparam logic [NODE_W-1:0] NODE_COUNT_RESET = 10'd1023;

    // count memory operations
    typedef enum logic [1:0] {
        CNT_IDLE,
        CNT_READ,
        CNT_BUMP,
        CNT_WIPE
    } cnt_op_t;

    typedef struct packed {
        cnt_op_t             op;
        logic [NODE_W-1:0]   node;
    } cnt_req_t;

    // tree memory port requests
    typedef struct packed {
        logic                rd_en;
        logic [NODE_W-1:0]   rd_node;
        logic                wr_en;
        logic [NODE_W-1:0]   wr_node;
        logic [NODE_W-1:0]   wr_parent;
        logic [TAG_W-1:0]    wr_tag;
    } tree_req_t;

    // decoded tree read data
    typedef struct packed {
        logic [NODE_W-1:0]   parent_raw;
        logic [NODE_W-1:0]   parent;
        logic                marked;
    } tree_rsp_t;

    typedef struct packed {
        logic [NODE_W-1:0]   anc;
        logic [COUNT_W-1:0]  count;
        logic [STATUS_W-1:0] status;
    } result_t;

endpackage

### design/lca_tree_store.sv
// parent and ancestor-mark memory with registered read and entry decode
module lca_tree_store
    import lca_pkg::*;
#(
    parameter int ENTRIES = 1024
)
(
    input  logic              clk,
    input  tree_req_t         req,
    input  logic [NODE_W-1:0] limit,
    input  logic [TAG_W-1:0]  epoch,
    output tree_rsp_t         rsp
);

    localparam int ADDR_W = $clog2(ENTRIES);

    typedef struct packed {
        logic [NODE_W-1:0] parent;
        logic [TAG_W-1:0]  tag;
    } entry_t;

    entry_t mem [ENTRIES];
    entry_t rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_node[ADDR_W-1:0]] <= '{parent: req.wr_parent, tag: req.wr_tag};
        end
        if (req.rd_en)
        begin
            rdata_reg <= mem[req.rd_node[ADDR_W-1:0]];
        end
    end

    // stale parents above the limit act as roots, marks match the live epoch
    always_comb
    begin
        rsp.parent_raw = rdata_reg.parent;
        rsp.parent     = (rdata_reg.parent > limit) ? '0 : rdata_reg.parent;
        rsp.marked     = (rdata_reg.tag == epoch);
    end

endmodule

### design/lca_count_store.sv
// hit count memory with saturating read-modify-write
module lca_count_store
    import lca_pkg::*;
#(
    parameter int ENTRIES = 1024
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cnt_req_t           req,
    output logic [COUNT_W-1:0] count
);

    localparam int ADDR_W = $clog2(ENTRIES);

    logic [COUNT_W-1:0] mem [ENTRIES];
    logic [COUNT_W-1:0] rdata_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic               bump_pend_reg;
    logic [COUNT_W-1:0] bumped;
    logic               rd_en;

    assign rd_en = (req.op == CNT_READ) || (req.op == CNT_BUMP);

    // saturating increment of the value just read
    assign bumped = (rdata_reg == {COUNT_W{1'b1}}) ? rdata_reg : rdata_reg + COUNT_W'(1);
    assign count  = bump_pend_reg ? bumped : rdata_reg;

    // memory: bump write-back or wipe, registered read
    always_ff @(posedge clk)
    begin
        if (bump_pend_reg)
        begin
            mem[addr_reg] <= bumped;
        end
        else if (req.op == CNT_WIPE)
        begin
            mem[req.node[ADDR_W-1:0]] <= '0;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[req.node[ADDR_W-1:0]];
            addr_reg  <= req.node[ADDR_W-1:0];
        end
    end

    // pending write-back flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bump_pend_reg <= 1'b0;
        end
        else
        begin
            bump_pend_reg <= (req.op == CNT_BUMP);
        end
    end

endmodule

### design/lca_ctrl.sv
// request sequencer: range checks, two parent walks, sweeps and result hold
module lca_ctrl
    import lca_pkg::*;
#(
    parameter int LAST_NODE = 1023
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [KIND_W-1:0]   kind,
    input  logic [NODE_W-1:0]   first_node,
    input  logic [NODE_W-1:0]   second_node,
    input  logic [NODE_W-1:0]   node_count,
    input  logic                slot_free,
    output logic                res_push,
    output result_t             res,
    output tree_req_t           tree_req,
    input  tree_rsp_t           tree_rsp,
    output cnt_req_t            cnt_req,
    input  logic [COUNT_W-1:0]  cnt_count,
    output logic [NODE_W-1:0]   limit,
    output logic [TAG_W-1:0]    epoch
);

    localparam logic [NODE_W-1:0] LAST_N = NODE_W'(LAST_NODE);

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_READ_ISSUE,
        S_READ_WAIT,
        S_SCRUB,
        S_SCRUB_END,
        S_W1_ISSUE,
        S_W1_STEP,
        S_W2_ISSUE,
        S_W2_STEP,
        S_HIT_WAIT,
        S_WIPE,
        S_FINISH
    } state_t;

    state_t            state_reg, state_next;
    logic [NODE_W-1:0] a_reg, a_next;
    logic [NODE_W-1:0] b_reg, b_next;
    logic [NODE_W-1:0] t_reg, t_next;
    logic [NODE_W-1:0] step_reg, step_next;
    logic [NODE_W-1:0] sweep_reg, sweep_next;
    logic [TAG_W-1:0]  epoch_reg, epoch_next;
    logic              boot_reg, boot_next;
    result_t           res_reg, res_next;

    logic [NODE_W-1:0] step_inc;
    logic              a_bad, b_bad, b_over;

    assign limit    = (node_count > LAST_N) ? LAST_N : node_count;
    assign in_ready = (state_reg == S_IDLE);
    assign epoch    = epoch_reg;
    assign res      = res_reg;

    assign a_bad    = (first_node == '0) || (first_node > limit);
    assign b_over   = (second_node > limit);
    assign b_bad    = (second_node == '0) || b_over;
    assign step_inc = step_reg + NODE_W'(1);

    // next state and memory requests
    always_comb
    begin
        state_next = state_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        t_next     = t_reg;
        step_next  = step_reg;
        sweep_next = sweep_reg;
        epoch_next = epoch_reg;
        boot_next  = boot_reg;
        res_next   = res_reg;
        res_push   = 1'b0;
        tree_req   = '0;
        cnt_req.op   = CNT_IDLE;
        cnt_req.node = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    a_next = first_node;
                    b_next = second_node;
                    res_next = '{anc: '0, count: '0, status: ST_RANGE};
                    case (kind)
                        KIND_LOAD:
                        begin
                            state_next = (a_bad || b_over) ? S_FINISH : S_LOAD;
                        end
                        KIND_QUERY:
                        begin
                            t_next    = first_node;
                            step_next = '0;
                            if (a_bad || b_bad)
                            begin
                                state_next = S_FINISH;
                            end
                            else if (epoch_reg == TAG_MAX)
                            begin
                                sweep_next = '0;
                                state_next = S_SCRUB;
                            end
                            else
                            begin
                                epoch_next = epoch_reg + TAG_W'(1);
                                state_next = S_W1_ISSUE;
                            end
                        end
                        KIND_READ:
                        begin
                            state_next = a_bad ? S_FINISH : S_READ_ISSUE;
                        end
                        default:
                        begin
                            sweep_next = '0;
                            state_next = S_WIPE;
                        end
                    endcase
                end
            end

            // store one parent link
            S_LOAD:
            begin
                tree_req.wr_en     = 1'b1;
                tree_req.wr_node   = a_reg;
                tree_req.wr_parent = b_reg;
                tree_req.wr_tag    = TAG_NONE;
                res_next   = '{anc: '0, count: '0, status: ST_OK};
                state_next = S_FINISH;
            end

            S_READ_ISSUE:
            begin
                cnt_req.op   = CNT_READ;
                cnt_req.node = a_reg;
                state_next   = S_READ_WAIT;
            end

            S_READ_WAIT:
            begin
                res_next   = '{anc: '0, count: cnt_count, status: ST_OK};
                state_next = S_FINISH;
            end

            // epoch wrap: reset every mark tag, keep parents
            S_SCRUB:
            begin
                tree_req.rd_en   = 1'b1;
                tree_req.rd_node = sweep_reg;
                if (sweep_reg != '0)
                begin
                    tree_req.wr_en     = 1'b1;
                    tree_req.wr_node   = sweep_reg - NODE_W'(1);
                    tree_req.wr_parent = tree_rsp.parent_raw;
                    tree_req.wr_tag    = TAG_NONE;
                end
                if (sweep_reg == LAST_N)
                begin
                    state_next = S_SCRUB_END;
                end
                else
                begin
                    sweep_next = sweep_reg + NODE_W'(1);
                end
            end

            S_SCRUB_END:
            begin
                tree_req.wr_en     = 1'b1;
                tree_req.wr_node   = LAST_N;
                tree_req.wr_parent = tree_rsp.parent_raw;
                tree_req.wr_tag    = TAG_NONE;
                epoch_next = TAG_FIRST;
                state_next = S_W1_ISSUE;
            end

            S_W1_ISSUE:
            begin
                tree_req.rd_en   = 1'b1;
                tree_req.rd_node = t_reg;
                state_next       = S_W1_STEP;
            end

            // first walk: mark node, follow parent
            S_W1_STEP:
            begin
                tree_req.wr_en     = 1'b1;
                tree_req.wr_node   = t_reg;
                tree_req.wr_parent = tree_rsp.parent_raw;
                tree_req.wr_tag    = epoch_reg;
                if (tree_rsp.parent == '0)
                begin
                    t_next     = b_reg;
                    step_next  = '0;
                    state_next = S_W2_ISSUE;
                end
                else if (step_inc == limit)
                begin
                    res_next   = '{anc: '0, count: '0, status: ST_NO_ANC};
                    state_next = S_FINISH;
                end
                else
                begin
                    tree_req.rd_en   = 1'b1;
                    tree_req.rd_node = tree_rsp.parent;
                    t_next    = tree_rsp.parent;
                    step_next = step_inc;
                end
            end

            // one idle write slot so the last mark lands before the second walk
            S_W2_ISSUE:
            begin
                tree_req.rd_en   = 1'b1;
                tree_req.rd_node = t_reg;
                state_next       = S_W2_STEP;
            end

            // second walk: stop at the first marked node
            S_W2_STEP:
            begin
                if (tree_rsp.marked)
                begin
                    cnt_req.op   = CNT_BUMP;
                    cnt_req.node = t_reg;
                    state_next   = S_HIT_WAIT;
                end
                else if ((tree_rsp.parent == '0) || (step_inc == limit))
                begin
                    res_next   = '{anc: '0, count: '0, status: ST_NO_ANC};
                    state_next = S_FINISH;
                end
                else
                begin
                    tree_req.rd_en   = 1'b1;
                    tree_req.rd_node = tree_rsp.parent;
                    t_next    = tree_rsp.parent;
                    step_next = step_inc;
                end
            end

            S_HIT_WAIT:
            begin
                res_next   = '{anc: t_reg, count: cnt_count, status: ST_OK};
                state_next = S_FINISH;
            end

            // zero both tables, also run once after reset
            S_WIPE:
            begin
                tree_req.wr_en     = 1'b1;
                tree_req.wr_node   = sweep_reg;
                tree_req.wr_parent = '0;
                tree_req.wr_tag    = TAG_NONE;
                cnt_req.op   = CNT_WIPE;
                cnt_req.node = sweep_reg;
                if (sweep_reg == LAST_N)
                begin
                    if (boot_reg)
                    begin
                        boot_next  = 1'b0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        res_next   = '{anc: '0, count: '0, status: ST_OK};
                        state_next = S_FINISH;
                    end
                end
                else
                begin
                    sweep_next = sweep_reg + NODE_W'(1);
                end
            end

            // hand the result to the output register
            S_FINISH:
            begin
                if (slot_free)
                begin
                    res_push   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_WIPE;
            a_reg     <= '0;
            b_reg     <= '0;
            t_reg     <= '0;
            step_reg  <= '0;
            sweep_reg <= '0;
            epoch_reg <= TAG_NONE;
            boot_reg  <= 1'b1;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            a_reg     <= a_next;
            b_reg     <= b_next;
            t_reg     <= t_next;
            step_reg  <= step_next;
            sweep_reg <= sweep_next;
            epoch_reg <= epoch_next;
            boot_reg  <= boot_next;
            res_reg   <= res_next;
        end
    end

endmodule

### design/lowest_common_ancestor_counter_unit.sv
// top level: lowest common ancestor hit counter over a parent table
//
// Requests enter on in_valid/in_ready with kind, first_node and second_node;
// each request gives one result on out_valid/out_ready. node_count is set by
// cfg_write/cfg_data, which the user must write only while the unit is idle;
// the unit itself does not enforce this. One request is worked at a time. A
// query runs a first walk that marks nodes and a second walk that visits
// nodes looking for a mark, each walk step taking one read of the single
// parent memory port. Once the epoch tag has reached its maximum, the next
// query first rewrites the mark tags. After reset both tables are zeroed by
// a sweep of every entry with in_ready low; cfg writes are taken throughout.
// A finished result waits in the output register while the next request is
// accepted; if out_ready stays low the second result is held inside and no
// third request is taken until the register drains.
module lowest_common_ancestor_counter_unit
    import lca_pkg::*;
#(
    parameter int MAX_NODES = 1023
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [NODE_W-1:0]   cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [KIND_W-1:0]   kind,
    input  logic [NODE_W-1:0]   first_node,
    input  logic [NODE_W-1:0]   second_node,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [NODE_W-1:0]   ancestor_node,
    output logic [COUNT_W-1:0]  hit_count,
    output logic [STATUS_W-1:0] status
);

    localparam int NODE_MAX = (1 << NODE_W) - 1;
    localparam int LAST_NODE = (MAX_NODES < NODE_MAX) ? MAX_NODES : NODE_MAX;
    localparam int ENTRIES = LAST_NODE + 1;

    logic [NODE_W-1:0]   node_count_reg;
    logic                out_valid_reg;
    logic [NODE_W-1:0]   ancestor_node_reg;
    logic [COUNT_W-1:0]  hit_count_reg;
    logic [STATUS_W-1:0] status_reg;

    logic                slot_free;
    logic                res_push;
    result_t             res;
    tree_req_t           tree_req;
    tree_rsp_t           tree_rsp;
    cnt_req_t            cnt_req;
    logic [COUNT_W-1:0]  cnt_count;
    logic [NODE_W-1:0]   limit;
    logic [TAG_W-1:0]    epoch;

    assign slot_free     = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign ancestor_node = ancestor_node_reg;
    assign hit_count     = hit_count_reg;
    assign status        = status_reg;

    lca_ctrl #(
        .LAST_NODE (LAST_NODE)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .first_node  (first_node),
        .second_node (second_node),
        .node_count  (node_count_reg),
        .slot_free   (slot_free),
        .res_push    (res_push),
        .res         (res),
        .tree_req    (tree_req),
        .tree_rsp    (tree_rsp),
        .cnt_req     (cnt_req),
        .cnt_count   (cnt_count),
        .limit       (limit),
        .epoch       (epoch)
    );

    lca_tree_store #(
        .ENTRIES (ENTRIES)
    ) u_tree (
        .clk   (clk),
        .req   (tree_req),
        .limit (limit),
        .epoch (epoch),
        .rsp   (tree_rsp)
    );

    lca_count_store #(
        .ENTRIES (ENTRIES)
    ) u_count (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cnt_req),
        .count (cnt_count)
    );

    // node count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NODE_COUNT_RESET;
        end
        else if (cfg_write)
        begin
            node_count_reg <= cfg_data;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg     <= 1'b0;
            ancestor_node_reg <= '0;
            hit_count_reg     <= '0;
            status_reg        <= ST_OK;
        end
        else if (res_push)
        begin
            out_valid_reg     <= 1'b1;
            ancestor_node_reg <= res.anc;
            hit_count_reg     <= res.count;
            status_reg        <= res.status;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // a taken request always leaves the idle state
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while still ready");

    // only the three defined status codes reach the output
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_OK || status == ST_RANGE || status == ST_NO_ANC))
        else $error("undefined status code");

    // error results carry no ancestor and no count
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> (ancestor_node == '0) && (hit_count == '0))
        else $error("error result with nonzero payload");

    // a found ancestor has been counted at least once
    a_hit_counted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_OK) && (ancestor_node != '0) |-> (hit_count != '0))
        else $error("ancestor reported with zero count");

endmodule
